/* src/swtm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swtm_pkg
// Shared constants and types for the sliding-window trimmed mean block.
// ----------------------------------------------------------------------------
package swtm_pkg;

    localparam int WINDOW_MAX_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_DATA_W  = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int WLEN_W      = 6;
    localparam int TRIM_W      = 4;

    localparam logic [WLEN_W-1:0] WLEN_RST = 6'd5;
    localparam logic [TRIM_W-1:0] TRIM_RST = 4'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LENGTH = 2'd0,
        REG_TRIM_COUNT    = 2'd1
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RING,
        S_SWEEP,
        S_TAIL,
        S_FINISH,
        S_DIV,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

/* src/swtm_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swtm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swtm_div #(
    parameter int NW = 21,
    parameter int DW = 6
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic               done,
    output logic [NW-1:0]      quotient
);

    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [NW-1:0] quo_reg;
    logic [DW:0]   trial;
    logic          take;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign take  = (trial >= {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(NW);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (cnt_reg != '0)
        begin
            // remainder stays below divisor, so the low DW bits hold it
            rem_reg <= take ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], take};
        end
    end

    assign done     = (cnt_reg == CW'(1));
    assign quotient = {quo_reg[NW-2:0], take};

endmodule
`default_nettype wire

/* src/sliding_window_trimmed_mean_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Each sample passes through a one-entry-per-cycle sweep of the sorted memory and,
// when the window is ready, through the bit-serial divider. One sample in flight
// at a time.
// Reset (async, active low) empties the window and restores length 5, trim 2.
// ----------------------------------------------------------------------------
// sliding_window_trimmed_mean_top
// Window kept in an arrival ring and a sorted memory; trimmed mean per sample.
// ----------------------------------------------------------------------------
module sliding_window_trimmed_mean_top #(
    parameter int WINDOW_MAX  = swtm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swtm_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [swtm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [swtm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [SAMPLE_BITS-1:0]          sample,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [SAMPLE_BITS-1:0]               trimmed_mean,
    output logic                                 ready_res
);

    localparam int IDXW = $clog2(WINDOW_MAX);
    localparam int LENW = $clog2(WINDOW_MAX + 1);
    localparam int CMPW = ((LENW > swtm_pkg::WLEN_W) ? LENW : swtm_pkg::WLEN_W) + 1;
    localparam int SUMW = SAMPLE_BITS + IDXW;

    // configuration
    logic [swtm_pkg::WLEN_W-1:0] wlen_reg;
    logic [swtm_pkg::TRIM_W-1:0] trim_reg;
    logic [CMPW-1:0]             wl_ext, len_ext, trim_ext, trim2_ext, hi_ext;
    logic [LENW-1:0]             len;
    logic                        trim_ok;

    always_comb
    begin
        wl_ext = CMPW'(wlen_reg);
        if (wl_ext == '0)
            len_ext = CMPW'(1);
        else if (wl_ext > CMPW'(WINDOW_MAX))
            len_ext = CMPW'(WINDOW_MAX);
        else
            len_ext = wl_ext;
        trim_ext  = CMPW'(trim_reg);
        trim2_ext = CMPW'({trim_reg, 1'b0});
        hi_ext    = len_ext - trim_ext;
        len       = LENW'(len_ext);
        trim_ok   = (trim2_ext < len_ext);
    end

    // state
    swtm_pkg::state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0] s_reg, s_next;
    logic [SAMPLE_BITS-1:0] rmv_reg, rmv_next;
    logic [SAMPLE_BITS-1:0] hold_reg, hold_next;
    logic                   hold_v_reg, hold_v_next;
    logic                   ins_reg, ins_next;
    logic                   rm_pend_reg, rm_pend_next;
    logic                   dval_reg, dval_next;
    logic [IDXW-1:0]        wp_reg, wp_next;
    logic [IDXW-1:0]        slot_reg, slot_next;
    logic [LENW-1:0]        fill_reg, fill_next;
    logic [LENW-1:0]        rd_reg, rd_next;
    logic [LENW-1:0]        wcnt_reg, wcnt_next;
    logic [SUMW-1:0]        sum_reg, sum_next;
    logic                   rdy_reg, rdy_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] mean_reg, mean_next;
    logic                   rres_reg, rres_next;
    logic [SAMPLE_BITS-1:0] pmean_reg, pmean_next;
    logic                   prres_reg, prres_next;

    // memories
    logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] sort_mem [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] ring_rdata_reg;
    logic [SAMPLE_BITS-1:0] sort_rdata_reg;
    logic                   ring_we;
    logic                   sort_re;
    logic                   sort_we;
    logic [SAMPLE_BITS-1:0] sort_wdata;
    logic [IDXW-1:0]        slot_c;

    // divider
    logic                   div_start;
    logic                   div_done;
    logic [SUMW-1:0]        div_quo;
    logic [LENW-1:0]        divisor;

    logic accept_in;
    logic out_take;
    logic cfg_hit;

    assign accept_in = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign cfg_hit   = cfg_we && ((cfg_index == swtm_pkg::REG_WINDOW_LENGTH) ||
                                  (cfg_index == swtm_pkg::REG_TRIM_COUNT));
    assign slot_c    = (LENW'(wp_reg) >= len) ? '0 : wp_reg;
    assign divisor   = LENW'(len_ext - trim2_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= swtm_pkg::WLEN_RST;
            trim_reg <= swtm_pkg::TRIM_RST;
        end
        else if (cfg_we && (cfg_index == swtm_pkg::REG_WINDOW_LENGTH))
        begin
            wlen_reg <= cfg_data[swtm_pkg::WLEN_W-1:0];
        end
        else if (cfg_we && (cfg_index == swtm_pkg::REG_TRIM_COUNT))
        begin
            trim_reg <= cfg_data[swtm_pkg::TRIM_W-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swtm_pkg::S_IDLE:   if (accept_in) state_next = swtm_pkg::S_RING;
            swtm_pkg::S_RING:   state_next = swtm_pkg::S_SWEEP;
            swtm_pkg::S_SWEEP:  if (!(rd_reg < fill_reg) && !dval_reg)
                                    state_next = swtm_pkg::S_TAIL;
            swtm_pkg::S_TAIL:   state_next = swtm_pkg::S_FINISH;
            swtm_pkg::S_FINISH: state_next = rdy_reg ? swtm_pkg::S_DIV : swtm_pkg::S_DONE;
            swtm_pkg::S_DIV:    if (div_done) state_next = swtm_pkg::S_DONE;
            swtm_pkg::S_DONE:   if (!out_valid_reg || out_take) state_next = swtm_pkg::S_IDLE;
            default:            state_next = swtm_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        s_next         = s_reg;
        rmv_next       = rmv_reg;
        hold_next      = hold_reg;
        hold_v_next    = hold_v_reg;
        ins_next       = ins_reg;
        rm_pend_next   = rm_pend_reg;
        dval_next      = 1'b0;
        wp_next        = wp_reg;
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        rd_next        = rd_reg;
        wcnt_next      = wcnt_reg;
        sum_next       = sum_reg;
        rdy_next       = rdy_reg;
        mean_next      = mean_reg;
        rres_next      = rres_reg;
        pmean_next     = pmean_reg;
        prres_next     = prres_reg;
        out_valid_next = out_take ? 1'b0 : out_valid_reg;
        ring_we        = 1'b0;
        sort_re        = 1'b0;
        sort_we        = 1'b0;
        sort_wdata     = s_reg;
        div_start      = 1'b0;
        in_stall       = (state_reg != swtm_pkg::S_IDLE);

        case (state_reg)
            swtm_pkg::S_IDLE:
            begin
                if (accept_in)
                begin
                    s_next    = sample;
                    slot_next = slot_c;
                end
            end
            swtm_pkg::S_RING:
            begin
                ring_we      = 1'b1;
                rmv_next     = ring_rdata_reg;
                rm_pend_next = (fill_reg >= len);
                wp_next      = (LENW'(slot_reg) + 1'b1 >= len) ? '0 : IDXW'(slot_reg + 1'b1);
                hold_v_next  = 1'b0;
                ins_next     = 1'b0;
                rd_next      = '0;
                wcnt_next    = '0;
                sum_next     = '0;
            end
            swtm_pkg::S_SWEEP:
            begin
                if (rd_reg < fill_reg)
                begin
                    sort_re   = 1'b1;
                    dval_next = 1'b1;
                    rd_next   = rd_reg + 1'b1;
                end
                if (dval_reg)
                begin
                    if (rm_pend_reg && (sort_rdata_reg == rmv_reg))
                    begin
                        // evicted sample drops out; a held value fills the gap
                        rm_pend_next = 1'b0;
                        if (hold_v_reg)
                        begin
                            sort_we     = 1'b1;
                            sort_wdata  = hold_reg;
                            hold_v_next = 1'b0;
                        end
                    end
                    else if (hold_v_reg)
                    begin
                        sort_we    = 1'b1;
                        sort_wdata = hold_reg;
                        hold_next  = sort_rdata_reg;
                    end
                    else if (!ins_reg && (sort_rdata_reg > s_reg))
                    begin
                        sort_we     = 1'b1;
                        sort_wdata  = s_reg;
                        hold_next   = sort_rdata_reg;
                        hold_v_next = 1'b1;
                        ins_next    = 1'b1;
                    end
                    else
                    begin
                        sort_we    = 1'b1;
                        sort_wdata = sort_rdata_reg;
                    end
                end
            end
            swtm_pkg::S_TAIL:
            begin
                if (hold_v_reg)
                begin
                    sort_we     = 1'b1;
                    sort_wdata  = hold_reg;
                    hold_v_next = 1'b0;
                end
                else if (!ins_reg)
                begin
                    sort_we    = 1'b1;
                    sort_wdata = s_reg;
                    ins_next   = 1'b1;
                end
            end
            swtm_pkg::S_FINISH:
            begin
                fill_next  = wcnt_reg;
                rdy_next   = (wcnt_reg == len) && trim_ok;
                div_start  = rdy_reg;
                pmean_next = '0;
                prres_next = 1'b0;
            end
            swtm_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    pmean_next = div_quo[SAMPLE_BITS-1:0];
                    prres_next = 1'b1;
                end
            end
            swtm_pkg::S_DONE:
            begin
                // result moves to the output register once it is free
                if (!out_valid_reg || out_take)
                begin
                    out_valid_next = 1'b1;
                    mean_next      = pmean_reg;
                    rres_next      = prres_reg;
                end
            end
            default:
            begin
            end
        endcase

        // running middle sum over the rebuilt sorted order
        if (sort_we)
        begin
            wcnt_next = wcnt_reg + 1'b1;
            if ((CMPW'(wcnt_reg) >= trim_ext) && (CMPW'(wcnt_reg) < hi_ext))
                sum_next = sum_reg + SUMW'(sort_wdata);
        end

        // FINISH reads the ready flag of this sample
        if (state_reg == swtm_pkg::S_TAIL)
            rdy_next = ((sort_we ? wcnt_reg + 1'b1 : wcnt_reg) == len) && trim_ok;

        if (cfg_hit)
        begin
            wp_next   = '0;
            fill_next = '0;
            sum_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swtm_pkg::S_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            dval_reg      <= 1'b0;
            hold_v_reg    <= 1'b0;
            ins_reg       <= 1'b0;
            rm_pend_reg   <= 1'b0;
            rdy_reg       <= 1'b0;
            rd_reg        <= '0;
            wcnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            dval_reg      <= dval_next;
            hold_v_reg    <= hold_v_next;
            ins_reg       <= ins_next;
            rm_pend_reg   <= rm_pend_next;
            rdy_reg       <= rdy_next;
            rd_reg        <= rd_next;
            wcnt_reg      <= wcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg     <= s_next;
        rmv_reg   <= rmv_next;
        hold_reg  <= hold_next;
        slot_reg  <= slot_next;
        mean_reg  <= mean_next;
        rres_reg  <= rres_next;
        pmean_reg <= pmean_next;
        prres_reg <= prres_next;
    end

    always_ff @(posedge clk)
    begin
        ring_rdata_reg <= ring_mem[slot_c];
        if (ring_we)
            ring_mem[slot_reg] <= s_reg;
    end

    always_ff @(posedge clk)
    begin
        if (sort_re)
            sort_rdata_reg <= sort_mem[rd_reg[IDXW-1:0]];
        if (sort_we)
            sort_mem[wcnt_reg[IDXW-1:0]] <= sort_wdata;
    end

    swtm_div #(
        .NW (SUMW),
        .DW (LENW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_valid    = out_valid_reg;
    assign trimmed_mean = mean_reg;
    assign ready_res    = rres_reg;

    // window never holds more than its capacity
    a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LENW'(WINDOW_MAX))
        else $error("fill count above capacity");

    // a held value exists only after the new sample went in
    a_hold_ins: assert property (@(posedge clk) disable iff (!rst_n)
        hold_v_reg |-> ins_reg)
        else $error("hold without insertion");

    // the rebuilt sorted order gains at most one entry per sample
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == swtm_pkg::S_FINISH) |-> (wcnt_reg <= fill_reg + 1'b1))
        else $error("sorted count grew by more than one");

    // a mean of nonzero is only reported with the ready flag
    a_mean_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rres_reg) |-> (mean_reg == '0))
        else $error("mean without ready");

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the sliding-window trimmed mean block against an in-bench predictor:
// directed window/trim corner settings, random samples over many register
// settings under three idle mixes, and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [swtm_pkg::CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [swtm_pkg::CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [15:0] mean;
        logic        rdy;
    } mean_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [swtm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [swtm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [15:0]                     sample = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [15:0]                     trimmed_mean;
    logic                            ready_res;

    // predictor state
    logic [swtm_pkg::WLEN_W-1:0] win_len_reg = swtm_pkg::WLEN_RST;
    logic [swtm_pkg::TRIM_W-1:0] trim_reg = swtm_pkg::TRIM_RST;
    logic [15:0]                 window_q[$];
    mean_result_t                expected_means[$];

    int errors = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_len = 0;

    sliding_window_trimmed_mean_top uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
        .out_valid(out_valid), .out_stall(out_stall),
        .trimmed_mean(trimmed_mean), .ready_res(ready_res)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic report(input string msg);
        errors++;
        $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    // output side: random stall, or a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_len > 0)
        begin
            out_stall <= 1'b1;
            hold_len--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        mean_result_t got;
        mean_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            got.mean = trimmed_mean;
            got.rdy = ready_res;
            if (expected_means.size() == 0)
                report($sformatf("unexpected result mean=%0d ready=%0b", got.mean, got.rdy));
            else
            begin
                exp_r = expected_means.pop_front();
                if (got.mean !== exp_r.mean)
                    report($sformatf("trimmed_mean %0d, want %0d", got.mean, exp_r.mean));
                if (got.rdy !== exp_r.rdy)
                    report($sformatf("ready_res %0b, want %0b", got.rdy, exp_r.rdy));
            end
        end
    end

    function automatic int eff_window();
        int w;
        w = win_len_reg;
        if (w == 0) w = 1;
        if (w > swtm_pkg::WINDOW_MAX_DEF) w = swtm_pkg::WINDOW_MAX_DEF;
        return w;
    endfunction

    // slide the window and work out the trimmed mean for one accepted sample
    task automatic predict_mean(input logic [15:0] s);
        logic [15:0]  srt[swtm_pkg::WINDOW_MAX_DEF];
        logic [15:0]  tmp;
        longint       sum;
        int           len;
        int           tr;
        int           j;
        mean_result_t r;
        len = eff_window();
        tr = trim_reg;
        if (window_q.size() >= len)
            void'(window_q.pop_front());
        window_q.push_back(s);
        r = '0;
        if (window_q.size() == len && 2 * tr < len)
        begin
            for (int i = 0; i < len; i++)
            begin
                srt[i] = window_q[i];
                j = i;
                while (j > 0 && srt[j-1] > srt[j])
                begin
                    tmp = srt[j];
                    srt[j] = srt[j-1];
                    srt[j-1] = tmp;
                    j--;
                end
            end
            sum = 0;
            for (int i = tr; i < len - tr; i++)
                sum += srt[i];
            r.mean = 16'(sum / (len - 2 * tr));
            r.rdy = 1'b1;
        end
        expected_means.push_back(r);
    endtask

    task automatic send_sample(input logic [15:0] v);
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample <= v;
        do @(posedge clk); while (in_stall);
        predict_mean(v);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_means.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [swtm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [swtm_pkg::CFG_DATA_W-1:0] d);
        wait_idle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == swtm_pkg::REG_WINDOW_LENGTH)
        begin
            win_len_reg = d;
            window_q.delete();
        end
        else if (idx == swtm_pkg::REG_TRIM_COUNT)
        begin
            trim_reg = d[swtm_pkg::TRIM_W-1:0];
            window_q.delete();
        end
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(3))
            0: return 16'($urandom_range(7));
            1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        // reset setting (5, 2): not full, then ready with extremes
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        send_sample(16'hFFFE);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        // unused indexes must neither flush nor change anything
        write_reg(REG_UNUSED_A, 6'h3F);
        write_reg(REG_UNUSED_B, 6'h00);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        // zero trim: mean of the whole window, all maxima
        write_reg(swtm_pkg::REG_TRIM_COUNT, 6'd0);
        write_reg(swtm_pkg::REG_WINDOW_LENGTH, 6'd4);
        repeat (5) send_sample(16'hFFFF);
        // ties at the trim boundaries
        write_reg(swtm_pkg::REG_WINDOW_LENGTH, 6'd3);
        write_reg(swtm_pkg::REG_TRIM_COUNT, 6'd1);
        repeat (3) send_sample(16'h0007);
        send_sample(16'h0002);
        // trim too large: never ready
        write_reg(swtm_pkg::REG_WINDOW_LENGTH, 6'd6);
        write_reg(swtm_pkg::REG_TRIM_COUNT, 6'd3);
        repeat (3) send_sample(16'h1234);
        // zero length acts as one, trim bits above the register dropped
        write_reg(swtm_pkg::REG_WINDOW_LENGTH, 6'd0);
        write_reg(swtm_pkg::REG_TRIM_COUNT, 6'h30);
        send_sample(16'hFFFF);
        send_sample(16'h0003);
    endtask

    task automatic test_random(input int s_pct, input int r_pct, input int n_items);
        int sent;
        int burst;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        // start at the largest setting: length saturates to the maximum, deepest trim
        write_reg(swtm_pkg::REG_WINDOW_LENGTH, 6'd63);
        write_reg(swtm_pkg::REG_TRIM_COUNT, 6'd15);
        sent = 0;
        while (sent < n_items)
        begin
            burst = $urandom_range(90, 30);
            for (int i = 0; i < burst && sent < n_items; i++)
            begin
                send_sample(rand_sample());
                sent++;
            end
            if ($urandom_range(9) == 0)
                write_reg(swtm_pkg::REG_WINDOW_LENGTH, 6'($urandom));
            else
                write_reg(swtm_pkg::REG_WINDOW_LENGTH, 6'($urandom_range(32, 3)));
            if ($urandom_range(9) == 0)
                write_reg(swtm_pkg::REG_TRIM_COUNT, 6'($urandom));
            else
                write_reg(swtm_pkg::REG_TRIM_COUNT,
                          6'($urandom_range((eff_window() - 1) / 2, 0)));
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(swtm_pkg::REG_WINDOW_LENGTH, 6'd5);
        write_reg(swtm_pkg::REG_TRIM_COUNT, 6'd1);
        hold_len = 400;
        repeat (12) send_sample(rand_sample());
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(29, 80, 640);
        test_random(80, 29, 640);
        test_random(0, 0, 640);
        test_backpressure();
        wait_idle();
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
